### src/drs_pkg.sv
package drs_pkg;

    typedef enum logic [2:0] {
        ALG_FIFO  = 3'd0,
        ALG_SSTF  = 3'd1,
        ALG_LOOK  = 3'd2,
        ALG_CLOOK = 3'd3,
        ALG_FLOOK = 3'd4
    } t_alg;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_PICKED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_PICK   = 1'b1;

    localparam int FIELD_BITS = 16;

    // Scan mode for one pass over the cell chain.
    typedef enum logic [1:0] {
        SCAN_DIR  = 2'd0,
        SCAN_DIST = 2'd1,
        SCAN_LOW  = 2'd2
    } t_scan;

    // Control sent from the sequencer to every cell.
    typedef struct packed {
        logic  shift;
        logic  load;
        logic  mark_all;
    } t_cell_ctrl;

endpackage

### src/drs_cell.sv
module drs_cell #(
    parameter int TRACK_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  drs_pkg::t_cell_ctrl         i_ctrl,
    input  logic                        i_load_here,
    input  logic                        i_keep,
    input  logic                        i_occupied,
    input  logic [TRACK_BITS-1:0]       i_load_track,
    input  logic [drs_pkg::FIELD_BITS-1:0] i_load_id,
    input  logic [TRACK_BITS-1:0]       i_next_track,
    input  logic [drs_pkg::FIELD_BITS-1:0] i_next_id,
    input  logic                        i_next_mark,
    output logic [TRACK_BITS-1:0]       o_track,
    output logic [drs_pkg::FIELD_BITS-1:0] o_id,
    output logic                        o_mark
);
    import drs_pkg::*;

    logic [TRACK_BITS-1:0] r_track;
    logic [FIELD_BITS-1:0] r_id;
    logic                  r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
        end else if (i_ctrl.load && i_load_here) begin
            r_mark <= 1'b0;
        end else if (i_ctrl.shift && !i_keep) begin
            r_mark <= i_next_mark;
        end else if (i_ctrl.mark_all && i_occupied) begin
            r_mark <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && i_load_here) begin
            r_track <= i_load_track;
            r_id    <= i_load_id;
        end else if (i_ctrl.shift && !i_keep) begin
            r_track <= i_next_track;
            r_id    <= i_next_id;
        end
    end

    assign o_track = r_track;
    assign o_id    = r_id;
    assign o_mark  = r_mark;
endmodule

### src/disk_request_scheduler.sv
// Disk request scheduler over a chain of DEPTH storage cells, one item in flight.
// An insert or an empty pick goes straight to presenting its status; a fifo pick
// takes the head cell, compacts the chain and presents the result; a scanning pick
// walks the occupied cells one per cycle in at most two passes, then compacts and
// presents the pick, or presents empty if no cell qualifies. The next item is
// accepted in the cycle after the result transaction. Synchronous active-low reset
// empties the store, clears batch marks, selects fifo and sets the sweep up.
module disk_request_scheduler #(
    parameter int DEPTH      = 16,
    parameter int TRACK_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_track,
    input  logic [15:0] i_request_id,
    input  logic [15:0] i_head_track,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_algorithm,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_picked_id,
    output logic [15:0] o_picked_track,
    output logic        o_moving_up
);
    import drs_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = TRACK_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SECOND, S_TAKE, S_OUT
    } t_state;

    t_state                r_state;
    logic [2:0]            r_alg;
    logic [CW-1:0]         r_count;
    logic                  r_up;
    logic [TRACK_BITS-1:0] r_head;
    logic [IW-1:0]         r_idx;
    logic                  r_found;
    logic [IW-1:0]         r_best;
    logic [DW-1:0]         r_best_d;
    logic                  r_valid;
    logic [1:0]            r_status;
    logic [15:0]           r_pid;
    logic [15:0]           r_ptrk;
    t_scan                 r_mode;
    logic                  r_marked;
    logic                  r_dir;

    logic [TRACK_BITS-1:0] w_track [DEPTH];
    logic [15:0]           w_id    [DEPTH];
    logic                  w_mark  [DEPTH];
    t_cell_ctrl            w_ctrl;

    assign o_cfg_ready = (r_state == S_IDLE) && !r_valid;
    assign o_ready     = (r_state == S_IDLE) && !r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alg <= ALG_FIFO;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_alg <= i_cfg_algorithm;
        end
    end

    logic any_mark;
    always_comb begin
        any_mark = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_mark[i]) any_mark = 1'b1;
        end
    end

    // Current cell in the scan.
    logic [TRACK_BITS-1:0] cur_t;
    logic [DW-1:0]         cur_d;
    logic                  cur_ok;
    logic                  last;
    assign cur_t = w_track[r_idx];
    assign cur_d = (cur_t >= r_head) ? DW'(cur_t - r_head) : DW'(r_head - cur_t);
    assign last  = (CW'(r_idx) + 1'b1) >= r_count;

    always_comb begin
        unique case (r_mode)
            SCAN_DIR:  cur_ok = (r_dir ? (cur_t >= r_head) : (cur_t <= r_head))
                                && (!r_marked || w_mark[r_idx])
                                && (!r_found || cur_d < r_best_d);
            SCAN_DIST: cur_ok = !r_found || cur_d < r_best_d;
            SCAN_LOW:  cur_ok = !r_found || cur_t < w_track[r_best];
            default:   cur_ok = 1'b0;
        endcase
    end

    logic                  take_ok;
    logic [IW-1:0]         take_idx;
    assign take_ok  = r_found || cur_ok;
    assign take_idx = cur_ok ? r_idx : r_best;

    logic [IW-1:0] r_take;
    logic          fifo_like;
    assign fifo_like = !(r_alg == ALG_SSTF || r_alg == ALG_LOOK ||
                         r_alg == ALG_CLOOK || r_alg == ALG_FLOOK);

    always_comb begin
        w_ctrl.shift    = (r_state == S_TAKE);
        w_ctrl.load     = (r_state == S_IDLE) && i_valid && o_ready &&
                          (i_opcode == OP_INSERT) && (r_count < CW'(DEPTH));
        w_ctrl.mark_all = (r_state == S_IDLE) && i_valid && o_ready &&
                          (i_opcode == OP_PICK) && (r_alg == ALG_FLOOK) && !any_mark;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_up    <= 1'b1;
            r_valid <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_head     <= TRACK_BITS'(i_head_track);
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_marked   <= (r_alg == ALG_FLOOK);
                        if (i_opcode == OP_INSERT) begin
                            r_status <= (r_count < CW'(DEPTH)) ? ST_INSERTED : ST_FULL;
                            if (r_count < CW'(DEPTH)) r_count <= r_count + 1'b1;
                            r_pid   <= '0;
                            r_ptrk  <= '0;
                            r_state <= S_OUT;
                        end else if (r_count == '0) begin
                            r_status <= ST_EMPTY;
                            r_pid    <= '0;
                            r_ptrk   <= '0;
                            r_state  <= S_OUT;
                        end else if (fifo_like) begin
                            r_take <= '0;
                            r_up   <= w_track[0] > TRACK_BITS'(i_head_track);
                            r_state <= S_TAKE;
                        end else begin
                            r_mode  <= (r_alg == ALG_SSTF) ? SCAN_DIST : SCAN_DIR;
                            r_dir   <= (r_alg == ALG_CLOOK) ? 1'b1 : r_up;
                            if (r_alg == ALG_CLOOK) r_up <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN, S_SECOND: begin
                    if (last) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        if (take_ok) begin
                            r_take  <= take_idx;
                            r_state <= S_TAKE;
                            if (r_mode == SCAN_DIST)
                                r_up <= w_track[take_idx] >= r_head;
                        end else if (r_state == S_SECOND) begin
                            r_status <= ST_EMPTY;
                            r_pid    <= '0;
                            r_ptrk   <= '0;
                            r_state  <= S_OUT;
                        end else if (r_alg == ALG_CLOOK) begin
                            r_mode  <= SCAN_LOW;
                            r_up    <= 1'b0;
                            r_state <= S_SECOND;
                        end else begin
                            r_dir   <= !r_dir;
                            r_up    <= !r_dir;
                            r_state <= S_SECOND;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        if (cur_ok) begin
                            r_found  <= 1'b1;
                            r_best   <= r_idx;
                            r_best_d <= cur_d;
                        end
                    end
                end
                S_TAKE: begin
                    r_status <= ST_PICKED;
                    r_pid    <= w_id[r_take];
                    r_ptrk   <= 16'(w_track[r_take]);
                    r_count  <= r_count - 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                  nm;
        logic [TRACK_BITS-1:0] nt;
        logic [15:0]           ni;
        if (g + 1 < DEPTH) begin : g_mid
            assign nt = w_track[g+1];
            assign ni = w_id[g+1];
            assign nm = (CW'(g + 1) < r_count) ? w_mark[g+1] : 1'b0;
        end else begin : g_end
            assign nt = w_track[g];
            assign ni = w_id[g];
            assign nm = 1'b0;
        end
        drs_cell #(.TRACK_BITS(TRACK_BITS)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_load_here (r_count == CW'(g)),
            .i_keep      (IW'(g) < r_take),
            .i_occupied  (CW'(g) < r_count),
            .i_load_track(TRACK_BITS'(i_track)),
            .i_load_id   (i_request_id),
            .i_next_track(nt),
            .i_next_id   (ni),
            .i_next_mark (nm),
            .o_track     (w_track[g]),
            .o_id        (w_id[g]),
            .o_mark      (w_mark[g])
        );
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_picked_id    = r_pid;
    assign o_picked_track = r_ptrk;
    assign o_moving_up    = r_up;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("entry count overflow");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_take_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pick did not remove an entry");
`endif
endmodule
